// File: rtl/gsp_pkg.sv
// shared types, codes and constants of the grid shortest path search
`default_nettype none
package gsp_pkg;

    localparam int CELL_W       = 12;
    localparam int SIDE_W       = 7;
    localparam int DIST_W       = 12;
    localparam int DEF_MAX_SIDE = 64;

    localparam logic [DIST_W-1:0] DIST_MAX = 12'hFFF;

    localparam logic [SIDE_W-1:0] SIDE_MIN   = 7'd5;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd20;
    localparam logic [CELL_W-1:0] START_RESET = 12'd0;
    localparam logic [CELL_W-1:0] END_RESET   = 12'd1;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] CFG_SIDE  = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    localparam logic [1:0] MARK_NONE    = 2'd0;
    localparam logic [1:0] MARK_VISITED = 2'd1;
    localparam logic [1:0] MARK_PATH    = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [2:0] CS_EMPTY    = 3'd0;
    localparam logic [2:0] CS_OBSTACLE = 3'd1;
    localparam logic [2:0] CS_START    = 3'd2;
    localparam logic [2:0] CS_END      = 3'd3;
    localparam logic [2:0] CS_VISITED  = 3'd4;
    localparam logic [2:0] CS_PATH     = 3'd5;

    localparam logic [1:0] RS_FOUND   = 2'd0;
    localparam logic [1:0] RS_UNREACH = 2'd1;
    localparam logic [1:0] RS_BAD     = 2'd2;

    typedef struct packed {
        logic       obstacle;
        logic [1:0] mark;
    } t_map_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [1:0]        back;
    } t_path_word;

    typedef struct packed {
        logic              rd_en;
        logic [CELL_W-1:0] rd_addr;
        logic              map_we;
        logic [CELL_W-1:0] map_addr;
        t_map_word         map_data;
        logic              path_we;
        logic [CELL_W-1:0] path_addr;
        t_path_word        path_data;
    } t_mem_req;

    typedef struct packed {
        t_map_word  map;
        t_path_word path;
    } t_mem_rsp;

endpackage
`default_nettype wire

// File: rtl/gsp_cell_mem.sv
// cell memories: obstacle and mark per cell, distance and back direction per cell
`default_nettype none
module gsp_cell_mem #(
    parameter int MAX_SIDE = gsp_pkg::DEF_MAX_SIDE
) (
    input  wire logic              i_clk,
    input  wire gsp_pkg::t_mem_req i_req,
    output gsp_pkg::t_mem_rsp      o_rsp
);
    import gsp_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    t_map_word  r_map_mem  [DEPTH];
    t_path_word r_path_mem [DEPTH];
    t_mem_rsp   r_rsp;

    always_ff @(posedge i_clk) begin
        if (i_req.map_we) begin
            r_map_mem[i_req.map_addr[AW-1:0]] <= i_req.map_data;
        end
        if (i_req.path_we) begin
            r_path_mem[i_req.path_addr[AW-1:0]] <= i_req.path_data;
        end
        if (i_req.rd_en) begin
            r_rsp.map  <= r_map_mem[i_req.rd_addr[AW-1:0]];
            r_rsp.path <= r_path_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rsp = r_rsp;

endmodule
`default_nettype wire

// File: rtl/grid_shortest_path_search.sv
// top level: request handling and search sequencer of the grid shortest path search
`default_nettype none
// A cell write gives no reply beat. A cell read is answered from the memory, or without it
// when it names the start or end cell or lies outside the grid. After reset a clearing
// sweep writes every entry of the obstacle and mark memory while no request beat is
// taken. A run first sweeps the whole memory, reading and rewriting each entry, to reset
// marks and distances, then scans the grid once per distance level in index order,
// reading each cell and, for each cell on the level, each of its neighbors in the grid,
// and then traces the path back from the end cell one step at a time.
// All of these steps share the single read port of the cell memories.
module grid_shortest_path_search #(
    parameter int MAX_SIDE = gsp_pkg::DEF_MAX_SIDE
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [gsp_pkg::CELL_W-1:0] i_cfg_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [gsp_pkg::CELL_W-1:0] i_cell_index,
    input  wire logic                      i_blocked,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [2:0]                     o_cell_state,
    output logic [1:0]                     o_run_status,
    output logic [gsp_pkg::CELL_W-1:0]     o_path_length
);
    import gsp_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RD_WAIT, S_CLR_RD, S_CLR_WR, S_SCAN_RD, S_SCAN_CHK,
        S_NB_RD, S_NB_CHK, S_NEXT, S_TR_RD, S_TR_CHK, S_DONE
    } t_state;

    t_state              r_state;
    logic [AW:0]         r_cnt;
    logic [SIDE_W-1:0]   r_side;
    logic [CELL_W-1:0]   r_start;
    logic [CELL_W-1:0]   r_end;
    logic [CELL_W-1:0]   r_u;
    logic [SIDE_W-1:0]   r_row;
    logic [SIDE_W-1:0]   r_col;
    logic [DIST_W-1:0]   r_level;
    logic [1:0]          r_dir;
    logic [CELL_W-1:0]   r_nb;
    logic                r_new;
    logic [CELL_W-1:0]   r_cur;
    logic [2:0]          r_res_state;
    logic [1:0]          r_res_status;
    logic [CELL_W-1:0]   r_res_len;
    logic                r_out_valid;
    logic [2:0]          r_out_state;
    logic [1:0]          r_out_status;
    logic [CELL_W-1:0]   r_out_len;

    t_mem_req            mem_req;
    t_mem_rsp            mem_rsp;

    logic [SIDE_W-1:0]   side_use;
    logic [SIDE_W-1:0]   side_last;
    logic [2*SIDE_W-1:0] n_cells;
    logic [CELL_W-1:0]   side_cells;
    logic [CELL_W-1:0]   last_cell;
    logic                in_grid;
    logic                write_ok;
    logic                bad_ends;
    logic                accept;
    logic [CELL_W-1:0]   nb_addr;
    logic                nb_ok;
    logic                relax;
    logic [CELL_W-1:0]   prev_cell;
    logic                clr_last;

    gsp_cell_mem #(.MAX_SIDE(MAX_SIDE)) u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    always_comb begin
        if (r_side < SIDE_MIN) begin
            side_use = SIDE_MIN;
        end else if (r_side > SIDE_W'(MAX_SIDE)) begin
            side_use = SIDE_W'(MAX_SIDE);
        end else begin
            side_use = r_side;
        end
    end

    assign side_last  = side_use - SIDE_W'(1);
    assign n_cells    = (2*SIDE_W)'(side_use) * (2*SIDE_W)'(side_use);
    assign side_cells = CELL_W'(side_use);
    assign last_cell  = CELL_W'(n_cells - (2*SIDE_W)'(1));
    assign in_grid    = (2*SIDE_W)'(i_cell_index) < n_cells;
    assign write_ok   = in_grid && (i_cell_index != r_start) && (i_cell_index != r_end);
    assign bad_ends   = ((2*SIDE_W)'(r_start) >= n_cells) || ((2*SIDE_W)'(r_end) >= n_cells)
                        || (r_start == r_end);
    assign accept     = i_in_valid && !o_in_stall;
    assign clr_last   = r_cnt == (AW+1)'(DEPTH - 1);

    always_comb begin
        unique case (r_dir)
            DIR_UP: begin
                nb_addr = r_u - side_cells;
                nb_ok   = r_row != '0;
            end
            DIR_DOWN: begin
                nb_addr = r_u + side_cells;
                nb_ok   = r_row != side_last;
            end
            DIR_LEFT: begin
                nb_addr = r_u - CELL_W'(1);
                nb_ok   = r_col != '0;
            end
            default: begin
                nb_addr = r_u + CELL_W'(1);
                nb_ok   = r_col != side_last;
            end
        endcase
    end

    always_comb begin
        unique case (mem_rsp.path.back)
            DIR_UP:   prev_cell = r_cur + side_cells;
            DIR_DOWN: prev_cell = r_cur - side_cells;
            DIR_LEFT: prev_cell = r_cur + CELL_W'(1);
            default:  prev_cell = r_cur - CELL_W'(1);
        endcase
    end

    assign relax = (!mem_rsp.map.obstacle || (r_nb == r_end))
                   && (mem_rsp.path.distance == DIST_MAX);

    always_comb begin
        mem_req = '0;
        unique case (r_state)
            S_INIT: begin
                mem_req.map_we   = 1'b1;
                mem_req.map_addr = CELL_W'(r_cnt[AW-1:0]);
            end
            S_IDLE: begin
                if (accept && (i_req_type == REQ_WRITE) && write_ok) begin
                    mem_req.map_we        = 1'b1;
                    mem_req.map_addr      = i_cell_index;
                    mem_req.map_data.obstacle = i_blocked;
                    mem_req.map_data.mark     = MARK_NONE;
                end
                if (accept && (i_req_type == REQ_READ) && in_grid) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = i_cell_index;
                end
            end
            S_CLR_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = CELL_W'(r_cnt[AW-1:0]);
            end
            S_CLR_WR: begin
                mem_req.map_we            = 1'b1;
                mem_req.map_addr          = CELL_W'(r_cnt[AW-1:0]);
                mem_req.map_data.obstacle = mem_rsp.map.obstacle;
                mem_req.map_data.mark     = MARK_NONE;
                mem_req.path_we           = 1'b1;
                mem_req.path_addr         = CELL_W'(r_cnt[AW-1:0]);
                mem_req.path_data.distance =
                    (CELL_W'(r_cnt[AW-1:0]) == r_start) ? '0 : DIST_MAX;
                mem_req.path_data.back    = DIR_UP;
            end
            S_SCAN_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_u;
            end
            S_NB_RD: begin
                mem_req.rd_en   = nb_ok;
                mem_req.rd_addr = nb_addr;
            end
            S_NB_CHK: begin
                if (relax) begin
                    mem_req.path_we        = 1'b1;
                    mem_req.path_addr      = r_nb;
                    mem_req.path_data.distance = r_level + DIST_W'(1);
                    mem_req.path_data.back = r_dir;
                    if (r_nb != r_end) begin
                        mem_req.map_we            = 1'b1;
                        mem_req.map_addr          = r_nb;
                        mem_req.map_data.obstacle = 1'b0;
                        mem_req.map_data.mark     = MARK_VISITED;
                    end
                end
            end
            S_TR_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_cur;
            end
            S_TR_CHK: begin
                if (prev_cell != r_start) begin
                    mem_req.map_we            = 1'b1;
                    mem_req.map_addr          = prev_cell;
                    mem_req.map_data.obstacle = 1'b0;
                    mem_req.map_data.mark     = MARK_PATH;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_side      <= SIDE_RESET;
            r_start     <= START_RESET;
            r_end       <= END_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                priority case (i_cfg_index)
                    CFG_SIDE:  r_side  <= i_cfg_data[SIDE_W-1:0];
                    CFG_START: r_start <= i_cfg_data;
                    CFG_END:   r_end   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + (AW+1)'(1);
                    if (clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_res_state  <= CS_EMPTY;
                        r_res_status <= RS_FOUND;
                        r_res_len    <= '0;
                        r_u          <= i_cell_index;
                        priority case (i_req_type)
                            REQ_RUN: begin
                                if (bad_ends) begin
                                    r_res_status <= RS_BAD;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_cnt   <= '0;
                                    r_state <= S_CLR_RD;
                                end
                            end
                            REQ_READ: begin
                                if (!in_grid) begin
                                    r_state <= S_DONE;
                                end else if (i_cell_index == r_start) begin
                                    r_res_state <= CS_START;
                                    r_state     <= S_DONE;
                                end else if (i_cell_index == r_end) begin
                                    r_res_state <= CS_END;
                                    r_state     <= S_DONE;
                                end else begin
                                    r_state <= S_RD_WAIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    if (mem_rsp.map.obstacle) begin
                        r_res_state <= CS_OBSTACLE;
                    end else if (mem_rsp.map.mark == MARK_VISITED) begin
                        r_res_state <= CS_VISITED;
                    end else if (mem_rsp.map.mark == MARK_PATH) begin
                        r_res_state <= CS_PATH;
                    end
                    r_state <= S_DONE;
                end
                S_CLR_RD: begin
                    r_state <= S_CLR_WR;
                end
                S_CLR_WR: begin
                    r_cnt <= r_cnt + (AW+1)'(1);
                    if (clr_last) begin
                        r_level <= '0;
                        r_u     <= '0;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_new   <= 1'b0;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_state <= S_CLR_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (mem_rsp.path.distance != r_level) begin
                        r_state <= S_NEXT;
                    end else if (r_u == r_end) begin
                        r_res_len <= r_level;
                        r_cur     <= r_end;
                        r_state   <= S_TR_RD;
                    end else begin
                        r_dir   <= DIR_UP;
                        r_state <= S_NB_RD;
                    end
                end
                S_NB_RD: begin
                    r_nb <= nb_addr;
                    if (nb_ok) begin
                        r_state <= S_NB_CHK;
                    end else if (r_dir == DIR_RIGHT) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dir <= r_dir + 2'd1;
                    end
                end
                S_NB_CHK: begin
                    if (relax) begin
                        r_new <= 1'b1;
                    end
                    if (r_dir == DIR_RIGHT) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_NB_RD;
                    end
                end
                S_NEXT: begin
                    if (r_u == last_cell) begin
                        if (r_new) begin
                            r_level <= r_level + DIST_W'(1);
                            r_u     <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_new   <= 1'b0;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_res_status <= RS_UNREACH;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_u <= r_u + CELL_W'(1);
                        if (r_col == side_last) begin
                            r_col <= '0;
                            r_row <= r_row + SIDE_W'(1);
                        end else begin
                            r_col <= r_col + SIDE_W'(1);
                        end
                        r_state <= S_SCAN_RD;
                    end
                end
                S_TR_RD: begin
                    r_state <= S_TR_CHK;
                end
                S_TR_CHK: begin
                    r_cur <= prev_cell;
                    if (prev_cell == r_start) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TR_RD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_state  <= r_res_state;
                        r_out_status <= r_res_status;
                        r_out_len    <= r_res_len;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_cell_state  = r_out_state;
    assign o_run_status  = r_out_status;
    assign o_path_length = r_out_len;

`ifndef SYNTHESIS
    a_idle_no_path_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_req.path_we)
        else $error("distance memory written outside a run");

    a_trace_skips_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TR_CHK && mem_req.map_we) |-> (mem_req.map_addr != r_start))
        else $error("path mark written on the start cell");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB_CHK) |-> (r_level != DIST_MAX))
        else $error("search level overflow");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a pending beat");
`endif

endmodule
`default_nettype wire
